// ----- src/emmc_pkg.sv -----
package emmc_pkg;

  localparam int unsigned STORE_DEPTH = 65536;
  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned LEFT_W      = 15;

  typedef enum logic [1:0] {
    OP_CMD  = 2'd0,
    OP_WR   = 2'd1,
    OP_RD   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_INVALID = 2'd2,
    ST_NO_XFER = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_WRITE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_EXT   = 2'd3
  } kind_e;

  localparam logic [5:0] CMD_GO_IDLE      = 6'd0;
  localparam logic [5:0] CMD_SEND_OP_COND = 6'd1;
  localparam logic [5:0] CMD_ALL_SEND_CID = 6'd2;
  localparam logic [5:0] CMD_SET_RCA      = 6'd3;
  localparam logic [5:0] CMD_IO_OP_COND   = 6'd5;
  localparam logic [5:0] CMD_SWITCH       = 6'd6;
  localparam logic [5:0] CMD_SEND_EXT_CSD = 6'd8;
  localparam logic [5:0] CMD_SEND_CSD     = 6'd9;
  localparam logic [5:0] CMD_SEND_CID     = 6'd10;
  localparam logic [5:0] CMD_STOP         = 6'd12;
  localparam logic [5:0] CMD_SEND_STATUS  = 6'd13;
  localparam logic [5:0] CMD_READ_SINGLE  = 6'd17;
  localparam logic [5:0] CMD_READ_MULTI   = 6'd18;
  localparam logic [5:0] CMD_WRITE_SINGLE = 6'd24;
  localparam logic [5:0] CMD_WRITE_MULTI  = 6'd25;
  localparam logic [5:0] CMD_APP_OP_COND  = 6'd41;

  localparam logic [31:0] OCR_WORD    = 32'h00FF8080;
  localparam logic [31:0] STATUS_WORD = 32'h00000900;

  localparam logic [3:0][31:0] CID_WORDS = {
    32'h4D430001, 32'h414C454D, 32'h49525455, 32'h15010056
  };
  localparam logic [3:0][31:0] CSD_WORDS = {
    32'h0A404001, 32'h00007F7F, 32'h5B590000, 32'h400E0032
  };

  localparam logic [7:0] EXT_STRUCTURE = 8'h05;
  localparam logic [7:0] EXT_CARD_TYPE = 8'h07;
  localparam logic [7:0] EXT_REVISION  = 8'h15;

  typedef struct packed {
    logic [15:0]       rca;
    kind_e             kind;
    logic [ADDR_W-1:0] ptr;
    logic [LEFT_W-1:0] left;
  } xfer_st_t;

  typedef struct packed {
    status_e         status;
    logic [3:0][31:0] resp;
    logic [63:0]     data;
    logic            use_ram;
    logic            last;
  } rslt_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
  } mem_ctl_t;

endpackage

// ----- src/emmc_card_command_responder.sv -----
// eMMC card responder: takes one host item (command, write-data beat or
// read-data request) per cycle while in_stall_o is low and returns exactly
// one result beat per item. State update and at most one access to the
// sector RAM happen at the accept edge; the result then passes through a
// holding stage and an output register, the RAM's registered read joining
// it at the output register. The output register lets the next item in
// while a result waits. After reset the sector RAM is swept to zero, one
// word per cycle over all 65536 words, and no item is taken before it ends.
module emmc_card_command_responder #(
  parameter int unsigned SECTOR_COUNT = 1024,
  parameter int unsigned MAX_BLOCKS   = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [5:0]  command_index_i,
  input  logic [31:0] command_argument_i,
  input  logic [8:0]  block_count_i,
  input  logic [63:0] write_word_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] resp_word0_o,
  output logic [31:0] resp_word1_o,
  output logic [31:0] resp_word2_o,
  output logic [31:0] resp_word3_o,
  output logic [63:0] read_word_o,
  output logic        last_word_o
);

  localparam int unsigned AW = emmc_pkg::ADDR_W;

  emmc_pkg::xfer_st_t st_q, st_d;
  emmc_pkg::rslt_t    rslt;
  emmc_pkg::mem_ctl_t mem_ctl;

  logic          clr_busy_q;
  logic [AW-1:0] clr_cnt_q;

  logic                a_valid_q;
  emmc_pkg::rslt_t     a_q;
  logic                b_valid_q;
  emmc_pkg::status_e   b_status_q;
  logic [3:0][31:0]    b_resp_q;
  logic [63:0]         b_data_q;
  logic                b_last_q;

  logic          accept;
  logic          b_load;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [63:0]   ram_wdata;
  logic [63:0]   ram_rdata;

  emmc_step #(
    .SECTOR_COUNT (SECTOR_COUNT),
    .MAX_BLOCKS   (MAX_BLOCKS)
  ) u_step (
    .op_i               (emmc_pkg::op_e'(op_i)),
    .command_index_i    (command_index_i),
    .command_argument_i (command_argument_i),
    .block_count_i      (block_count_i),
    .cur_i              (st_q),
    .nxt_o              (st_d),
    .rslt_o             (rslt),
    .mem_o              (mem_ctl)
  );

  // holding stage A drains into output stage B whenever B is free or taken
  assign b_load     = a_valid_q && (!b_valid_q || !out_stall_i);
  assign in_stall_o = clr_busy_q || (a_valid_q && b_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  assign ram_we    = clr_busy_q || (accept && mem_ctl.we);
  assign ram_waddr = clr_busy_q ? clr_cnt_q : mem_ctl.addr;
  assign ram_wdata = clr_busy_q ? '0 : write_word_i;

  emmc_ram #(
    .WIDTH (64),
    .DEPTH (emmc_pkg::STORE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept && mem_ctl.re),
    .raddr_i (mem_ctl.addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
      if (clr_cnt_q == '1) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.rca  <= 16'd1;
      st_q.kind <= emmc_pkg::KIND_NONE;
      st_q.ptr  <= '0;
      st_q.left <= '0;
    end else if (accept) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        a_valid_q <= 1'b1;
      end else if (b_load) begin
        a_valid_q <= 1'b0;
      end
      if (b_load) begin
        b_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q <= rslt;
    end
    if (b_load) begin
      b_status_q <= a_q.status;
      b_resp_q   <= a_q.resp;
      b_data_q   <= a_q.use_ram ? ram_rdata : a_q.data;
      b_last_q   <= a_q.last;
    end
  end

  assign out_valid_o  = b_valid_q;
  assign status_o     = b_status_q;
  assign resp_word0_o = b_resp_q[0];
  assign resp_word1_o = b_resp_q[1];
  assign resp_word2_o = b_resp_q[2];
  assign resp_word3_o = b_resp_q[3];
  assign read_word_o  = b_data_q;
  assign last_word_o  = b_last_q;

endmodule

// ----- src/emmc_ram.sv -----
module emmc_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/emmc_step.sv -----
module emmc_step #(
  parameter int unsigned SECTOR_COUNT = 1024,
  parameter int unsigned MAX_BLOCKS   = 256
) (
  input  emmc_pkg::op_e      op_i,
  input  logic [5:0]         command_index_i,
  input  logic [31:0]        command_argument_i,
  input  logic [8:0]         block_count_i,
  input  emmc_pkg::xfer_st_t cur_i,
  output emmc_pkg::xfer_st_t nxt_o,
  output emmc_pkg::rslt_t    rslt_o,
  output emmc_pkg::mem_ctl_t mem_o
);

  localparam logic [31:0] SC_WORD   = 32'(SECTOR_COUNT);
  localparam logic [32:0] SC_LIMIT  = 33'(SECTOR_COUNT);
  localparam logic [15:0] BLK_LIMIT = 16'(MAX_BLOCKS);

  // word positions inside the 512-byte extended CSD
  localparam logic [5:0] EXT_W_STRUCT = 6'd24;
  localparam logic [5:0] EXT_W_SEC    = 6'd26;
  localparam logic [5:0] EXT_W_REV    = 6'd28;

  logic [32:0]                 end_sector;
  logic [emmc_pkg::LEFT_W-1:0] left_dec;
  logic [63:0]                 ext_word;

  assign end_sector = {1'b0, command_argument_i} + {24'b0, block_count_i};
  assign left_dec   = cur_i.left - 1'b1;

  always_comb begin
    unique case (cur_i.ptr[5:0])
      EXT_W_STRUCT: ext_word = {24'b0, emmc_pkg::EXT_CARD_TYPE, 24'b0,
                                emmc_pkg::EXT_STRUCTURE};
      EXT_W_SEC:    ext_word = {SC_WORD, 32'b0};
      EXT_W_REV:    ext_word = {emmc_pkg::EXT_REVISION, 56'b0};
      default:      ext_word = '0;
    endcase
  end

  always_comb begin
    nxt_o          = cur_i;
    rslt_o         = '0;
    rslt_o.status  = emmc_pkg::ST_OK;
    mem_o          = '0;
    mem_o.addr     = cur_i.ptr;

    unique case (op_i)
      emmc_pkg::OP_CMD: begin
        unique case (command_index_i)
          emmc_pkg::CMD_GO_IDLE: begin
            nxt_o.rca  = '0;
            nxt_o.kind = emmc_pkg::KIND_NONE;
            nxt_o.ptr  = '0;
            nxt_o.left = '0;
          end
          emmc_pkg::CMD_SEND_OP_COND: rslt_o.resp[0] = emmc_pkg::OCR_WORD;
          emmc_pkg::CMD_ALL_SEND_CID,
          emmc_pkg::CMD_SEND_CID:     rslt_o.resp = emmc_pkg::CID_WORDS;
          emmc_pkg::CMD_SET_RCA: begin
            nxt_o.rca      = command_argument_i[31:16];
            rslt_o.resp[0] = {command_argument_i[31:16], 16'h0001};
          end
          emmc_pkg::CMD_IO_OP_COND,
          emmc_pkg::CMD_APP_OP_COND:  rslt_o.status = emmc_pkg::ST_TIMEOUT;
          emmc_pkg::CMD_SWITCH,
          emmc_pkg::CMD_SEND_STATUS:  rslt_o.resp[0] = emmc_pkg::STATUS_WORD;
          emmc_pkg::CMD_SEND_CSD:     rslt_o.resp = emmc_pkg::CSD_WORDS;
          emmc_pkg::CMD_STOP: begin
            nxt_o.kind = emmc_pkg::KIND_NONE;
            nxt_o.ptr  = '0;
            nxt_o.left = '0;
          end
          emmc_pkg::CMD_SEND_EXT_CSD: begin
            if (block_count_i != '0) begin
              nxt_o.kind = emmc_pkg::KIND_EXT;
              nxt_o.ptr  = '0;
              nxt_o.left = emmc_pkg::LEFT_W'(64);
            end
          end
          emmc_pkg::CMD_READ_SINGLE,
          emmc_pkg::CMD_READ_MULTI,
          emmc_pkg::CMD_WRITE_SINGLE,
          emmc_pkg::CMD_WRITE_MULTI: begin
            if (block_count_i != '0) begin
              nxt_o.kind = emmc_pkg::KIND_NONE;
              nxt_o.ptr  = '0;
              nxt_o.left = '0;
              priority if ({7'b0, block_count_i} > BLK_LIMIT) begin
                rslt_o.status = emmc_pkg::ST_INVALID;
              end else if (end_sector > SC_LIMIT) begin
                rslt_o.status = emmc_pkg::ST_INVALID;
              end else begin
                nxt_o.kind = (command_index_i == emmc_pkg::CMD_WRITE_SINGLE ||
                              command_index_i == emmc_pkg::CMD_WRITE_MULTI)
                             ? emmc_pkg::KIND_WRITE : emmc_pkg::KIND_READ;
                nxt_o.ptr  = {command_argument_i[9:0], 6'b0};
                nxt_o.left = {block_count_i, 6'b0};
              end
            end
          end
          default: rslt_o.status = emmc_pkg::ST_INVALID;
        endcase
      end

      emmc_pkg::OP_WR,
      emmc_pkg::OP_RD: begin
        if (op_i == emmc_pkg::OP_WR && cur_i.kind == emmc_pkg::KIND_WRITE &&
            cur_i.left != '0) begin
          mem_o.we = 1'b1;
        end else if (op_i == emmc_pkg::OP_RD && cur_i.kind == emmc_pkg::KIND_READ &&
                     cur_i.left != '0) begin
          mem_o.re       = 1'b1;
          rslt_o.use_ram = 1'b1;
        end else if (op_i == emmc_pkg::OP_RD && cur_i.kind == emmc_pkg::KIND_EXT &&
                     cur_i.left != '0) begin
          rslt_o.data = ext_word;
        end else begin
          rslt_o.status = emmc_pkg::ST_NO_XFER;
        end

        if (rslt_o.status == emmc_pkg::ST_OK) begin
          nxt_o.ptr  = cur_i.ptr + 1'b1;
          nxt_o.left = left_dec;
          if (left_dec == '0) begin
            rslt_o.last = 1'b1;
            nxt_o.kind  = emmc_pkg::KIND_NONE;
            nxt_o.ptr   = '0;
          end
        end
      end

      default: rslt_o.status = emmc_pkg::ST_INVALID;
    endcase
  end

endmodule
